// ===== design/aimpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aimpq_pkg
// Shared types and constants for the ordered array insert and
// minimum-positive query block.
// ----------------------------------------------------------------------------
package aimpq_pkg;

    // Number of stored words.
    localparam int CAPACITY  = 64;
    // Most position reports that a single query transaction produces.
    localparam int OUT_LIMIT = 64;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int TOT_W  = $clog2(OUT_LIMIT + 1);
    localparam int IDX_W  = 6;
    localparam int WORD_W = 32;
    localparam int MINV_W = 31;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_REPORT   = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef struct packed
    {
        logic               cmd;
        logic signed [31:0] value;
        logic signed [31:0] position;
    } request_t;

    typedef struct packed
    {
        logic [1:0]        status;
        logic [MINV_W-1:0] min_value;
        logic [IDX_W-1:0]  index;
        logic              last;
    } result_t;

    // State of the minimum search that the scan unit hands to the sequencer.
    typedef struct packed
    {
        logic              found;
        logic [MINV_W-1:0] min_value;
        logic [TOT_W-1:0]  total;
    } scan_stat_t;

endpackage

// ===== design/aimpq_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aimpq_scan
// Running search for the smallest strictly positive word in a stream of
// memory reads, with a saturating tally of how often it occurs.
// ----------------------------------------------------------------------------
module aimpq_scan
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          vld,
    input  logic [aimpq_pkg::WORD_W-1:0]  data,
    output aimpq_pkg::scan_stat_t         stat
);

    logic                           found_reg;
    logic                           found_next;
    logic [aimpq_pkg::MINV_W-1:0]   minv_reg;
    logic [aimpq_pkg::MINV_W-1:0]   minv_next;
    logic [aimpq_pkg::TOT_W-1:0]    total_reg;
    logic [aimpq_pkg::TOT_W-1:0]    total_next;
    logic                           positive;

    // A word counts when it is nonzero and its sign bit is clear.
    assign positive = (data != '0) && !data[aimpq_pkg::WORD_W-1];

    always_comb
    begin
        found_next = found_reg;
        minv_next  = minv_reg;
        total_next = total_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (vld && positive)
        begin
            if (!found_reg || (data[aimpq_pkg::MINV_W-1:0] < minv_reg))
            begin
                found_next = 1'b1;
                minv_next  = data[aimpq_pkg::MINV_W-1:0];
                total_next = aimpq_pkg::TOT_W'(1);
            end
            else if ((data[aimpq_pkg::MINV_W-1:0] == minv_reg) &&
                     (total_reg != aimpq_pkg::TOT_W'(aimpq_pkg::OUT_LIMIT)))
            begin
                total_next = total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minv_reg  <= minv_next;
        total_reg <= total_next;
    end

    assign stat.found     = found_reg;
    assign stat.min_value = minv_reg;
    assign stat.total     = total_reg;

endmodule

// ===== design/array_insert_min_positive_query.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_min_positive_query
// Ordered word array with positional insert and a query that reports every
// index holding the smallest strictly positive stored value.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   -------------------------------------
//  request   start high, busy low    cmd, value, position
//  result    result_valid, 1 cycle   status, min_value, index, last
//
// Every transaction is handled alone; busy stays high until its final result
// has been placed on the result register. An append, a rejected insert and a
// query on an empty array answer in the cycle after start without raising
// busy. An insert that has to move entries uses one memory read and one write
// per moved word. A query makes a minimum search pass over the word memory
// and, if a positive word was found, a report pass that stops after the last
// matching index. The receiver cannot stall results.
// Reset clears the fill count and the sequencer; the memory holds no reset.
//
module array_insert_min_positive_query
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  aimpq_pkg::request_t   request,
    output logic                  result_valid,
    output aimpq_pkg::result_t    result
);

    localparam int AW = aimpq_pkg::ADDR_W;
    localparam int CW = aimpq_pkg::CNT_W;
    localparam int TW = aimpq_pkg::TOT_W;

    // Sequencer states, one-hot.
    typedef enum logic [7:0]
    {
        S_IDLE     = 8'b0000_0001,
        S_SHIFT    = 8'b0000_0010,
        S_DRAIN    = 8'b0000_0100,
        S_PLACE    = 8'b0000_1000,
        S_SCAN     = 8'b0001_0000,
        S_SCAN_END = 8'b0010_0000,
        S_DECIDE   = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Word memory, single write port and one registered read port.
    logic [aimpq_pkg::WORD_W-1:0] mem [aimpq_pkg::CAPACITY];
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [aimpq_pkg::WORD_W-1:0] wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [aimpq_pkg::WORD_W-1:0] rd_data_reg;

    // Control registers.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] ptr_next;
    logic          rd_vld_reg;
    logic          rd_vld_next;
    logic          pend_vld_reg;
    logic          pend_vld_next;
    logic [TW-1:0] emitted_reg;
    logic [TW-1:0] emitted_next;
    logic          out_vld_reg;
    logic          out_vld_next;

    // Payload registers.
    logic [AW-1:0]                rd_addr_reg;
    logic [AW-1:0]                rd_addr_next;
    logic [AW-1:0]                pend_addr_reg;
    logic [AW-1:0]                pend_addr_next;
    logic [AW-1:0]                pos_reg;
    logic [AW-1:0]                pos_next;
    logic [aimpq_pkg::WORD_W-1:0] value_reg;
    logic [aimpq_pkg::WORD_W-1:0] value_next;
    aimpq_pkg::result_t           out_reg;
    aimpq_pkg::result_t           out_next;

    // Insert position after clamping to the range 0 to count.
    logic [AW-1:0] pos_clamped;
    logic          pos_is_end;
    logic          req_ok;

    // Minimum search.
    logic                  scan_clear;
    logic                  scan_vld;
    aimpq_pkg::scan_stat_t scan_stat;
    logic                  match;
    logic                  is_last;

    assign req_ok = start && (state_reg == S_IDLE);

    always_comb
    begin
        if (request.position[31])
        begin
            pos_clamped = '0;
        end
        else if ($unsigned(request.position) > 32'(count_reg))
        begin
            pos_clamped = AW'(count_reg);
        end
        else
        begin
            pos_clamped = AW'(request.position);
        end
    end

    assign pos_is_end = (CW'(pos_clamped) == count_reg);

    // Only the minimum search pass feeds the scan unit.
    assign scan_vld = rd_vld_reg && ((state_reg == S_SCAN) || (state_reg == S_SCAN_END));

    aimpq_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (scan_clear),
        .vld   (scan_vld),
        .data  (rd_data_reg),
        .stat  (scan_stat)
    );

    assign match   = rd_vld_reg && (rd_data_reg == {1'b0, scan_stat.min_value});
    assign is_last = (TW'(emitted_reg + 1'b1) == scan_stat.total);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        rd_vld_next    = 1'b0;
        pend_vld_next  = 1'b0;
        emitted_next   = emitted_reg;
        out_vld_next   = 1'b0;
        rd_addr_next   = rd_addr_reg;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        out_next       = '0;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[AW-1:0];
        scan_clear     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_ok)
                begin
                    if (request.cmd == aimpq_pkg::CMD_INSERT)
                    begin
                        if (count_reg == CW'(aimpq_pkg::CAPACITY))
                        begin
                            out_vld_next   = 1'b1;
                            out_next.status = aimpq_pkg::ST_REJECTED;
                            out_next.last  = 1'b1;
                        end
                        else if (pos_is_end)
                        begin
                            // Append: no entry has to move.
                            wr_en          = 1'b1;
                            wr_addr        = pos_clamped;
                            wr_data        = request.value;
                            count_next     = count_reg + 1'b1;
                            out_vld_next   = 1'b1;
                            out_next.status = aimpq_pkg::ST_INSERTED;
                            out_next.last  = 1'b1;
                        end
                        else
                        begin
                            pos_next   = pos_clamped;
                            value_next = request.value;
                            ptr_next   = count_reg - 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            out_vld_next   = 1'b1;
                            out_next.status = aimpq_pkg::ST_NONE;
                            out_next.last  = 1'b1;
                        end
                        else
                        begin
                            scan_clear = 1'b1;
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // Read entry ptr now, write it one place up next cycle. The
                // write lands two entries above the current read, so the
                // read never sees a stale word.
                if (pend_vld_reg)
                begin
                    wr_en = 1'b1;
                end
                rd_en          = 1'b1;
                pend_vld_next  = 1'b1;
                pend_addr_next = ptr_reg[AW-1:0] + 1'b1;
                if (ptr_reg[AW-1:0] == pos_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                end
            end

            S_DRAIN:
            begin
                wr_en      = 1'b1;
                state_next = S_PLACE;
            end

            S_PLACE:
            begin
                wr_en          = 1'b1;
                wr_addr        = pos_reg;
                wr_data        = value_reg;
                count_next     = count_reg + 1'b1;
                out_vld_next   = 1'b1;
                out_next.status = aimpq_pkg::ST_INSERTED;
                out_next.last  = 1'b1;
                state_next     = S_IDLE;
            end

            S_SCAN:
            begin
                rd_en       = 1'b1;
                rd_vld_next = 1'b1;
                ptr_next    = ptr_reg + 1'b1;
                if (ptr_reg == count_reg - 1'b1)
                begin
                    state_next = S_SCAN_END;
                end
            end

            S_SCAN_END:
            begin
                // The last word read arrives at the scan unit in this cycle.
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (!scan_stat.found)
                begin
                    out_vld_next   = 1'b1;
                    out_next.status = aimpq_pkg::ST_NONE;
                    out_next.last  = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ptr_next     = '0;
                    emitted_next = '0;
                    state_next   = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_addr_next = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + 1'b1;
                end
                if (match)
                begin
                    out_vld_next       = 1'b1;
                    out_next.status    = aimpq_pkg::ST_REPORT;
                    out_next.min_value = scan_stat.min_value;
                    out_next.index     = aimpq_pkg::IDX_W'(rd_addr_reg);
                    out_next.last      = is_last;
                    emitted_next       = emitted_reg + 1'b1;
                    if (is_last)
                    begin
                        rd_vld_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            emitted_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            emitted_reg  <= emitted_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        value_reg     <= value_next;
        out_reg       <= out_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule
